[rtl/tppc_pkg.sv]
// Package: shared types, constants and the prescaler code lookup for the timer period calculator.
`timescale 1ns / 1ps
`default_nettype none

package tppc_pkg;

    localparam int FIELD_W = 28;
    localparam int SHIFT_W = 5;

    localparam logic [27:0] CLOCK_RESET = 28'd48000000;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SAT     = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // Divider codes
    localparam logic [2:0] CODE_DIV1    = 3'd0;
    localparam logic [2:0] CODE_DIV64   = 3'd5;
    localparam logic [2:0] CODE_DIV256  = 3'd6;
    localparam logic [2:0] CODE_DIV1024 = 3'd7;

    // One division stage's working set
    typedef struct packed {
        logic [FIELD_W-1:0] rem;
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] quo;
        logic [FIELD_W-1:0] den;
        logic               bad;
    } div_t;

    function automatic logic [2:0] code_for_shift(input logic [SHIFT_W-1:0] sh);
        logic [2:0] code;
        if (sh <= 5'd4) begin
            code = sh[2:0];
        end else if (sh == 5'd6) begin
            code = CODE_DIV64;
        end else if (sh == 5'd8) begin
            code = CODE_DIV256;
        end else if (sh >= 5'd10) begin
            code = CODE_DIV1024;
        end else begin
            code = CODE_DIV1;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/tppc_div_stage.sv]
// Module: one registered step of the restoring divider pipeline (one quotient bit).
`timescale 1ns / 1ps
`default_nettype none

module tppc_div_stage
    import tppc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic valid_in,
    input  wire div_t data_in,
    output logic      valid_out,
    output div_t      data_out
);

    logic               valid_reg;
    div_t               data_reg;
    div_t               data_next;
    logic [FIELD_W:0]   trial;
    logic [FIELD_W:0]   diff;
    logic               take;

    always_comb begin
        trial = {data_in.rem, data_in.num[FIELD_W-1]};
        diff  = trial - {1'b0, data_in.den};
        take  = ~diff[FIELD_W];
        data_next     = data_in;
        // a refused trial is below the divisor, so it fits the field
        data_next.rem = take ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
        data_next.num = {data_in.num[FIELD_W-2:0], 1'b0};
        data_next.quo = {data_in.quo[FIELD_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[rtl/tppc_select.sv]
// Module: shift search, divider adjust and compare saturation, three register stages.
`timescale 1ns / 1ps
`default_nettype none

module tppc_select
    import tppc_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int MAX_SHIFT    = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire logic [FIELD_W-1:0] quo_in,
    input  wire logic               bad_in,
    output logic                    valid_out,
    output logic [2:0]              prescale_code,
    output logic [3:0]              divide_shift,
    output logic [15:0]             compare_top,
    output logic [1:0]              status
);

    localparam logic [32:0] TOP_LIMIT = 33'd1 << COUNTER_BITS;
    localparam logic [32:0] TOP_MAX   = TOP_LIMIT - 33'd1;
    localparam logic [SHIFT_W-1:0] MAX_SH = SHIFT_W'(MAX_SHIFT);

    // stage 1: smallest shift that fits the counter
    logic                   v1_reg;
    logic [FIELD_W-1:0]     q1_reg;
    logic                   bad1_reg;
    logic [SHIFT_W-1:0]     sh1_reg;
    logic [SHIFT_W-1:0]     sh1_next;
    logic [FIELD_W:0]       fits;

    always_comb begin
        for (int k = 0; k <= FIELD_W; k++) begin
            fits[k] = (({5'd0, quo_in} >> k) <= TOP_LIMIT);
        end
        sh1_next = SHIFT_W'(FIELD_W);
        for (int k = FIELD_W; k >= 0; k--) begin
            if (fits[k]) begin
                sh1_next = SHIFT_W'(k);
            end
        end
    end

    // stage 2: skip missing dividers, cap, shift the quotient
    logic                   v2_reg;
    logic                   bad2_reg;
    logic [SHIFT_W-1:0]     sh2_reg;
    logic [FIELD_W-1:0]     base2_reg;
    logic [SHIFT_W-1:0]     sh_adj;
    logic [SHIFT_W-1:0]     sh2_next;

    always_comb begin
        if (sh1_reg == 5'd5 || sh1_reg == 5'd7 || sh1_reg == 5'd9) begin
            sh_adj = sh1_reg + 5'd1;
        end else begin
            sh_adj = sh1_reg;
        end
        sh2_next = (sh_adj > MAX_SH) ? MAX_SH : sh_adj;
    end

    // stage 3: compare value and status
    logic                   v3_reg;
    logic [2:0]             code_reg;
    logic [3:0]             shift_reg;
    logic [15:0]            cmp_reg;
    logic [1:0]             status_reg;
    logic [FIELD_W-1:0]     cmp_raw;
    logic                   sat;

    always_comb begin
        cmp_raw = (base2_reg == '0) ? '0 : base2_reg - FIELD_W'(1);
        sat     = ({5'd0, cmp_raw} > TOP_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg    <= quo_in;
            bad1_reg  <= bad_in;
            sh1_reg   <= sh1_next;
            bad2_reg  <= bad1_reg;
            sh2_reg   <= sh2_next;
            base2_reg <= q1_reg >> sh2_next;
            if (bad2_reg) begin
                code_reg   <= CODE_DIV1;
                shift_reg  <= 4'd0;
                cmp_reg    <= 16'd0;
                status_reg <= STATUS_INVALID;
            end else begin
                code_reg   <= code_for_shift(sh2_reg);
                shift_reg  <= sh2_reg[3:0];
                cmp_reg    <= sat ? TOP_MAX[15:0] : cmp_raw[15:0];
                status_reg <= sat ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign valid_out     = v3_reg;
    assign prescale_code = code_reg;
    assign divide_shift  = shift_reg;
    assign compare_top   = cmp_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

[rtl/timer_prescaler_period_calc_top.sv]
// Pipeline: 28 divider stages, then 3 select stages, from input transfer to result.
// Throughput: one request per cycle; the whole pipeline holds while a result is not taken.
// The 28-stage restoring divider for clock / rate sets the depth.
// Reset: synchronous active-low aresetn clears all valid bits and loads clock_hz = 48000000.
// Configuration writes are taken at once whenever cfg_we is high.
`timescale 1ns / 1ps
`default_nettype none

module timer_prescaler_period_calc_top
    import tppc_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int MAX_SHIFT    = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [27:0] cfg_wdata,     // clock_hz
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // [27:0] request_hz, [31:28] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata        // [2:0] prescale_code, [6:3] divide_shift,
                                            // [22:7] compare_top, [24:23] status, rest zero
);

    logic [FIELD_W-1:0] clock_hz_reg;
    logic               en;
    logic [FIELD_W-1:0] req;
    div_t               stage_data [0:FIELD_W];
    logic               stage_valid [0:FIELD_W];
    logic [2:0]         prescale_code;
    logic [3:0]         divide_shift;
    logic [15:0]        compare_top;
    logic [1:0]         status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_RESET;
        end else if (cfg_we) begin
            clock_hz_reg <= cfg_wdata;
        end
    end

    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;
    assign req      = s_tdata[FIELD_W-1:0];

    assign stage_valid[0] = s_tvalid;
    // zero rate, or rate above the clock
    assign stage_data[0]  = '{rem: '0, num: clock_hz_reg, quo: '0, den: req,
                              bad: (req == '0) || (req > clock_hz_reg)};

    for (genvar g = 0; g < FIELD_W; g++) begin : g_div
        tppc_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (stage_valid[g]),
            .data_in   (stage_data[g]),
            .valid_out (stage_valid[g+1]),
            .data_out  (stage_data[g+1])
        );
    end

    tppc_select #(
        .COUNTER_BITS (COUNTER_BITS),
        .MAX_SHIFT    (MAX_SHIFT)
    ) u_select (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .valid_in      (stage_valid[FIELD_W]),
        .quo_in        (stage_data[FIELD_W].quo),
        .bad_in        (stage_data[FIELD_W].bad),
        .valid_out     (m_tvalid),
        .prescale_code (prescale_code),
        .divide_shift  (divide_shift),
        .compare_top   (compare_top),
        .status        (status)
    );

    assign m_tdata = {7'd0, status, compare_top, divide_shift, prescale_code};

`ifndef NO_ASSERTIONS
    localparam logic [32:0] TOP_MAX_CHK = (33'd1 << COUNTER_BITS) - 33'd1;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status == STATUS_INVALID) |->
            (prescale_code == CODE_DIV1 && divide_shift == 4'd0 && compare_top == 16'd0))
        else $error("invalid result with nonzero fields");

    a_sat_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status == STATUS_SAT) |->
            (compare_top == TOP_MAX_CHK[15:0] && divide_shift == 4'(MAX_SHIFT)))
        else $error("saturated result without full top at largest shift");

    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(stage_valid[FIELD_W]) && $stable(stage_data[FIELD_W].quo))
        else $error("divider pipeline moved during a stall");
`endif

endmodule

`default_nettype wire
